/* src/heightmap_vertex_normal_generator_assert.svh */
// assertion macros for the heightmap vertex normal generator
`ifndef HEIGHTMAP_VERTEX_NORMAL_GENERATOR_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMAL_GENERATOR_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define HVN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvn port check failed");

// next-cycle implication, checked on clk, off during reset
`define HVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvn port check failed");

`endif

/* src/hvn_pkg.sv */
// shared types and constants of the heightmap vertex normal generator
`default_nettype none
package hvn_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int SAMPLE_W   = 8;
  localparam int OUT_POS_W  = 10;
  localparam int NORMAL_W   = 16;
  localparam int MAG_W      = 10;
  localparam int SQ_W       = 20;
  localparam int M_W        = 15;
  localparam int D_W        = 16;
  localparam int DSQ_W      = 32;
  localparam int PROD_W     = 52;
  localparam int BIT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_DIV = 2'd2;

  localparam logic [CFG_W-1:0]    RESET_WIDTH  = 11'd256;
  localparam logic [CFG_W-1:0]    RESET_HEIGHT = 11'd256;
  localparam logic [SAMPLE_W-1:0] RESET_DIV    = 8'd1;
  localparam logic [SAMPLE_W-1:0] DIV_ZERO_Q   = 8'd255;

  // y weight 40 squared
  localparam logic [SQ_W-1:0]     NY_SQ        = 20'd1600;
  localparam logic [MAG_W-1:0]    NY_MAG       = 10'd40;
  localparam logic [NORMAL_W-1:0] Q15_ONE      = 16'sd32767;
  localparam logic [BIT_W-1:0]    TOP_BIT      = 4'd14;
  localparam logic [1:0]          COMP_X       = 2'd0;
  localparam logic [1:0]          COMP_Y       = 2'd1;
  localparam logic [1:0]          COMP_Z       = 2'd2;
  localparam logic [3:0]          DIV_STEPS    = 4'd8;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PLAN  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_START = 7'b0010000,
    S_NORM  = 7'b0100000,
    S_OUT   = 7'b1000000
  } hvn_state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic load;
    logic start;
    logic finish;
    logic sel_b;
  } hvn_cmd_t;

  typedef struct packed {
    logic has_a;
    logic has_b;
    logic norm_done;
  } hvn_status_t;

endpackage
`default_nettype wire

/* src/hvn_ctrl.sv */
// controller state machine sequencing one sample through its results
`default_nettype none
module hvn_ctrl
  import hvn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire hvn_status_t status,
  output hvn_cmd_t         cmd
);

  hvn_state_t state_r, state_nxt;
  logic       sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    cmd        = '0;
    cmd.sel_b  = sel_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        if (status.has_a) begin
          sel_nxt   = 1'b0;
          state_nxt = S_READ;
        end else if (status.has_b) begin
          sel_nxt   = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (status.norm_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (!sel_r && status.has_b) begin
            sel_nxt   = 1'b1;
            state_nxt = S_READ;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/hvn_norm.sv */
// bit-serial normalizer: three q1.15 components of a vector over its length
`default_nettype none
module hvn_norm
  import hvn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [MAG_W-1:0]    ax,
  input  wire logic [MAG_W-1:0]    az,
  input  wire logic                neg_x,
  input  wire logic                neg_z,
  output logic                     done,
  output logic signed [NORMAL_W-1:0] res_x,
  output logic signed [NORMAL_W-1:0] res_y,
  output logic signed [NORMAL_W-1:0] res_z
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              phase_r, phase_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [M_W-1:0]    m_r, m_nxt;
  logic [DSQ_W-1:0]  dsq_r, dsq_nxt;
  logic [SQ_W-1:0]   sqx_r, sqz_r, len2_r;
  logic              negx_r, negz_r;
  logic signed [NORMAL_W-1:0] rx_r, ry_r, rz_r;

  logic [M_W-1:0]    m_try;
  logic [D_W-1:0]    d;
  logic [SQ_W-1:0]   sq_cur, sqx_in, sqz_in;
  logic              neg_cur;
  logic [PROD_W-1:0] prod, num;
  logic [M_W-1:0]    m_fin;
  logic signed [NORMAL_W-1:0] res_fin;

  assign sqx_in = SQ_W'(ax) * SQ_W'(ax);
  assign sqz_in = SQ_W'(az) * SQ_W'(az);
  assign m_try  = m_r | (M_W'(1) << bit_r);
  assign d      = {m_try, 1'b0} - D_W'(1);

  always_comb begin
    case (comp_r)
      COMP_X:  begin sq_cur = sqx_r; neg_cur = negx_r; end
      COMP_Y:  begin sq_cur = NY_SQ; neg_cur = 1'b0;   end
      default: begin sq_cur = sqz_r; neg_cur = negz_r; end
    endcase
  end

  // accept the candidate bit when (2m-1)^2 * len2 <= v^2 * 2^32
  assign prod    = PROD_W'(dsq_r) * PROD_W'(len2_r);
  assign num     = {sq_cur, 32'd0};
  assign m_fin   = (prod <= num) ? m_try : m_r;
  assign res_fin = neg_cur ? -$signed({1'b0, m_fin}) : $signed({1'b0, m_fin});

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    m_nxt     = m_r;
    dsq_nxt   = dsq_r;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      comp_nxt  = COMP_X;
      bit_nxt   = TOP_BIT;
      m_nxt     = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        dsq_nxt   = DSQ_W'(d) * DSQ_W'(d);
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        m_nxt     = m_fin;
        if (bit_r == '0) begin
          m_nxt   = '0;
          bit_nxt = TOP_BIT;
          if (comp_r == COMP_Z) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    comp_r  <= comp_nxt;
    bit_r   <= bit_nxt;
    m_r     <= m_nxt;
    dsq_r   <= dsq_nxt;
    if (start) begin
      sqx_r  <= sqx_in;
      sqz_r  <= sqz_in;
      len2_r <= sqx_in + NY_SQ + sqz_in;
      negx_r <= neg_x;
      negz_r <= neg_z;
    end
    if (busy_r && phase_r && bit_r == '0) begin
      case (comp_r)
        COMP_X:  rx_r <= res_fin;
        COMP_Y:  ry_r <= res_fin;
        default: rz_r <= res_fin;
      endcase
    end
  end

  assign done  = done_r;
  assign res_x = rx_r;
  assign res_y = ry_r;
  assign res_z = rz_r;

endmodule
`default_nettype wire

/* src/hvn_dp.sv */
// datapath: config, raster position, row store, divider and result registers
`default_nettype none
module hvn_dp
  import hvn_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [SAMPLE_W-1:0]  in_height_sample,
  input  wire hvn_cmd_t             cmd,
  output hvn_status_t               status,
  output logic [OUT_POS_W-1:0]      out_column,
  output logic [OUT_POS_W-1:0]      out_row,
  output logic [SAMPLE_W-1:0]       out_vertex_height,
  output logic signed [NORMAL_W-1:0] out_normal_x,
  output logic signed [NORMAL_W-1:0] out_normal_y,
  output logic signed [NORMAL_W-1:0] out_normal_z,
  output logic                      out_run_end,
  output logic                      out_map_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0]    width_r, height_r;
  logic [SAMPLE_W-1:0] div_r;
  logic [COL_W-1:0]    col_r, colq_r;
  logic [ROW_W-1:0]    row_r, rowq_r;
  logic                pv_r;
  logic [SAMPLE_W-1:0] pend_r, left_r, s_r, rdata_r, centre_r;
  logic                has_a_r, has_b_r, last_r;
  logic [SAMPLE_W-1:0] mem_r [MAX_WIDTH];

  logic [OUT_POS_W-1:0] ocol_r, orow_r;
  logic                 edge_r, run_end_r, map_end_r;
  logic [MAG_W-1:0]     ax_r, az_r;
  logic                 negx_r, negz_r;

  logic [SAMPLE_W-1:0]  rem_r, quo_r;
  logic [3:0]           dcnt_r;

  logic [31:0]          w32, h32;
  logic [COL_W-1:0]     wlast;
  logic [ROW_W-1:0]     hlast;
  logic                 col_ovf;
  logic [COL_W-1:0]     colq;
  logic [ROW_W-1:0]     rowq;
  logic [COL_W-1:0]     addr;
  logic [SAMPLE_W-1:0]  centre;
  logic signed [11:0]   nx, nz, dur;
  logic [SAMPLE_W:0]    rem_sh;
  logic                 nd;
  logic signed [NORMAL_W-1:0] rx, ry, rz;

  // effective map size, clamped to [2, max]
  always_comb begin
    w32 = 32'(width_r);
    h32 = 32'(height_r);
    if (w32 < 32'd2) w32 = 32'd2;
    if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    if (h32 < 32'd2) h32 = 32'd2;
    if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
  end
  assign wlast   = COL_W'(w32 - 32'd1);
  assign hlast   = ROW_W'(h32 - 32'd1);
  assign col_ovf = col_r > wlast;
  assign colq    = col_ovf ? '0 : col_r;
  assign rowq    = (row_r > hlast) ? '0 : row_r;

  assign addr   = cmd.sel_b ? colq_r : colq_r - COL_W'(1);
  assign centre = cmd.sel_b ? s_r : pend_r;

  // nx = left - right, nz = 2(up - right) - nx
  assign nx  = $signed({4'd0, left_r}) - $signed({4'd0, s_r});
  assign dur = $signed({4'd0, rdata_r}) - $signed({4'd0, s_r});
  assign nz  = (dur <<< 1) - nx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      div_r    <= RESET_DIV;
      col_r    <= '0;
      row_r    <= '0;
      pv_r     <= 1'b0;
      pend_r   <= '0;
      left_r   <= '0;
    end else begin
      if (cmd.load && !cmd.sel_b) left_r <= pend_r;
      if (cmd.finish) begin
        if (has_b_r) begin
          pv_r  <= 1'b0;
          col_r <= '0;
          row_r <= last_r ? '0 : rowq_r + ROW_W'(1);
        end else begin
          pend_r <= s_r;
          pv_r   <= 1'b1;
          col_r  <= colq_r + COL_W'(1);
          row_r  <= rowq_r;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_WIDTH: begin
            width_r <= cfg_wdata;
            col_r   <= '0;
            row_r   <= '0;
            pv_r    <= 1'b0;
          end
          REG_MAP_HEIGHT: begin
            height_r <= cfg_wdata;
            col_r    <= '0;
            row_r    <= '0;
            pv_r     <= 1'b0;
          end
          REG_HEIGHT_DIV: div_r <= cfg_wdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // per-sample plan and result operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r     <= in_height_sample;
      colq_r  <= colq;
      rowq_r  <= rowq;
      has_a_r <= pv_r && !col_ovf && colq != '0;
      has_b_r <= colq == wlast;
      last_r  <= rowq == hlast;
    end
    if (cmd.load) begin
      centre_r  <= centre;
      ocol_r    <= OUT_POS_W'(32'(addr));
      orow_r    <= OUT_POS_W'(32'(rowq_r));
      edge_r    <= addr == '0 || rowq_r == '0;
      run_end_r <= cmd.sel_b || !has_b_r;
      map_end_r <= cmd.sel_b && last_r;
      ax_r      <= MAG_W'(nx < 0 ? -nx : nx);
      az_r      <= MAG_W'(nz < 0 ? -nz : nz);
      negx_r    <= nx < 0;
      negz_r    <= nz < 0;
    end
  end

  // row store, registered read
  always_ff @(posedge clk) begin
    if (cmd.read) rdata_r <= mem_r[addr];
    if (cmd.load) mem_r[addr] <= centre;
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[SAMPLE_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= DIV_STEPS;
    end else if (cmd.start) begin
      dcnt_r <= '0;
    end else if (dcnt_r != DIV_STEPS) begin
      dcnt_r <= dcnt_r + 4'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= '0;
      quo_r <= centre_r;
    end else if (dcnt_r != DIV_STEPS) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_r <= SAMPLE_W'(rem_sh - {1'b0, div_r});
        quo_r <= {quo_r[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SAMPLE_W-1:0];
        quo_r <= {quo_r[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  hvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .ax    (ax_r),
    .az    (az_r),
    .neg_x (negx_r),
    .neg_z (negz_r),
    .done  (nd),
    .res_x (rx),
    .res_y (ry),
    .res_z (rz)
  );

  assign status.has_a     = has_a_r;
  assign status.has_b     = has_b_r;
  assign status.norm_done = nd;

  assign out_column        = ocol_r;
  assign out_row           = orow_r;
  assign out_vertex_height = (div_r == '0) ? DIV_ZERO_Q : quo_r;
  assign out_normal_x      = edge_r ? '0 : rx;
  assign out_normal_y      = edge_r ? $signed(Q15_ONE) : ry;
  assign out_normal_z      = edge_r ? '0 : rz;
  assign out_run_end       = run_end_r;
  assign out_map_end       = map_end_r;

endmodule
`default_nettype wire

/* src/heightmap_vertex_normal_generator.sv */
// top level of the heightmap vertex normal generator
`default_nettype none
// Samples arrive in raster order, one 8-bit height per beat; each grid point
// leaves one beat later as a vertex: column, row, sample / height_divisor and
// a unit normal in signed q1.15, from left, upper and right neighbours.
// Points in row 0 or column 0 carry (0, 32767, 0). The first sample of a row
// gives no beat, the last sample of a row gives two (the point before it,
// then itself, the right neighbour clamped to the centre). run_end marks the
// last beat of an input, map_end the final vertex of the map. Writing
// map_width or map_height restarts the map at its origin and drops the held
// sample. The block works on one sample at a time and takes no new sample
// until it is through with the one before. Each result steps through read,
// load, start, normalize and the output beat, normalizing in the one shared
// bit-serial normalizer that runs 15 bits for each of the three components,
// each bit a square phase, then a multiply and compare phase, and then flags
// done. The row store is a single-port memory of MAX_WIDTH bytes with
// registered read; it needs no clearing.
module heightmap_vertex_normal_generator
  import hvn_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   in_height_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_POS_W-1:0]       out_column,
  output logic [OUT_POS_W-1:0]       out_row,
  output logic [SAMPLE_W-1:0]        out_vertex_height,
  output logic signed [NORMAL_W-1:0] out_normal_x,
  output logic signed [NORMAL_W-1:0] out_normal_y,
  output logic signed [NORMAL_W-1:0] out_normal_z,
  output logic                       out_run_end,
  output logic                       out_map_end
);

  // command and status between sequencer and datapath
  hvn_cmd_t    cmd;
  hvn_status_t status;

  hvn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds config, position counters, row store and result beat
  hvn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_height_sample  (in_height_sample),
    .cmd               (cmd),
    .status            (status),
    .out_column        (out_column),
    .out_row           (out_row),
    .out_vertex_height (out_vertex_height),
    .out_normal_x      (out_normal_x),
    .out_normal_y      (out_normal_y),
    .out_normal_z      (out_normal_z),
    .out_run_end       (out_run_end),
    .out_map_end       (out_map_end)
  );

endmodule
`default_nettype wire

/* src/hvn_checker.sv */
// port-level checks for the heightmap vertex normal generator, with bind
`default_nettype none
`include "heightmap_vertex_normal_generator_assert.svh"
module hvn_checker
  import hvn_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [OUT_POS_W-1:0]  out_column,
  input wire logic signed [NORMAL_W-1:0] out_normal_y,
  input wire logic                  out_run_end,
  input wire logic                  out_map_end
);

  // a stalled result beat holds
  `HVN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_column))
  // one sample at a time: no intake while a result waits
  `HVN_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
  // the map's final vertex closes its input's results
  `HVN_ASSERT_IMPL(a_map_end_run, out_valid && out_map_end, out_run_end)
  // normal always points up
  `HVN_ASSERT_IMPL(a_ny_pos, out_valid, out_normal_y > 0)
  // intake closes after a sample is taken
  `HVN_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready)

endmodule

bind heightmap_vertex_normal_generator hvn_checker u_hvn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_column   (out_column),
  .out_normal_y (out_normal_y),
  .out_run_end  (out_run_end),
  .out_map_end  (out_map_end)
);
`default_nettype wire

/* sim/heightmap_vertex_normal_generator_test.sv */
// testbench of the heightmap vertex normal generator: scoreboard against a local predictor
`default_nettype none
module heightmap_vertex_normal_generator_test
  import hvn_pkg::*;
;

  // register index past the end of the list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int STORE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  // leave room for a result in flight before a register write
  localparam int SETTLE_CYCLES = 150;

  typedef struct packed {
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic [SAMPLE_W-1:0]  vh;
    logic [NORMAL_W-1:0]  nx;
    logic [NORMAL_W-1:0]  ny;
    logic [NORMAL_W-1:0]  nz;
    logic                 run_end;
    logic                 map_end;
  } vertex_t;

  typedef enum logic {STEP_SAMPLE, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [SAMPLE_W-1:0]  smp;
    logic                 typed;
    vertex_t              want;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [SAMPLE_W-1:0]        in_height_sample;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [OUT_POS_W-1:0]       out_column;
  logic [OUT_POS_W-1:0]       out_row;
  logic [SAMPLE_W-1:0]        out_vertex_height;
  logic signed [NORMAL_W-1:0] out_normal_x;
  logic signed [NORMAL_W-1:0] out_normal_y;
  logic signed [NORMAL_W-1:0] out_normal_z;
  logic                       out_run_end;
  logic                       out_map_end;

  heightmap_vertex_normal_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_height_sample (in_height_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_vertex_height(out_vertex_height),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_run_end      (out_run_end),
    .out_map_end      (out_map_end)
  );

  // ---------------------------------------------------------------------------
  // predictor state: mirror of the terrain walker
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] upper_row [STORE_DEPTH];
  logic [SAMPLE_W-1:0] held_sample;
  logic [SAMPLE_W-1:0] left_height;
  logic                held_valid;
  int unsigned         next_col;
  int unsigned         next_row;
  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  logic [SAMPLE_W-1:0] divisor_reg;

  vertex_t vertex_q[$];     // vertices still owed by the block

  int mismatches = 0;
  int vertices_seen = 0;
  int maps_seen = 0;
  int samples_sent;
  int cycles = 0;
  bit hold_request;         // sender asks the receiver for one long holdoff
  bit quiet_out;            // receiver stops idling for a stretch

  // q1.15 component of v over sqrt(len2), halves away from zero, saturated
  function automatic logic [NORMAL_W-1:0] unit_comp(int v, longint unsigned len2);
    longint unsigned mag, num, lo, hi, mid, d;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    num = (mag * mag) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * len2 <= num) lo = mid;
      else hi = mid - 1;
    end
    if (lo > 32767) lo = 32767;
    return (v < 0) ? NORMAL_W'(-lo) : NORMAL_W'(lo);
  endfunction

  function automatic vertex_t make_vertex(int unsigned c, int unsigned r,
                                          logic [7:0] centre, logic [7:0] lf,
                                          logic [7:0] up, logic [7:0] rt, logic last);
    vertex_t v;
    int nx, ny, nz;
    longint unsigned len2;
    v.col = OUT_POS_W'(c);
    v.row = OUT_POS_W'(r);
    v.vh  = (divisor_reg == 0) ? DIV_ZERO_Q : centre / divisor_reg;
    if (c == 0 || r == 0) begin
      // edge points point straight up
      v.nx = '0;
      v.ny = Q15_ONE;
      v.nz = '0;
    end else begin
      nx = int'(lf) - int'(rt);
      ny = NY_MAG;
      nz = 2 * (int'(up) - int'(rt)) - nx;
      len2 = longint'(nx * nx + ny * ny + nz * nz);
      v.nx = unit_comp(nx, len2);
      v.ny = unit_comp(ny, len2);
      v.nz = unit_comp(nz, len2);
    end
    v.run_end = 1'b0;
    v.map_end = last;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > STORE_DEPTH) return STORE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    if (height_reg > 1024) return 1024;
    return height_reg;
  endfunction

  // one accepted sample: advance the walker and list the vertices it releases
  function automatic void walk_sample(logic [7:0] s, ref vertex_t got[$]);
    int unsigned w, h, c, r, pc;
    logic last;
    w = eff_width();
    h = eff_height();
    c = next_col;
    r = next_row;
    got.delete();
    if (c >= w) begin
      c = 0;
      held_valid = 1'b0;
    end
    if (r >= h) r = 0;
    if (held_valid && c > 0) begin
      pc = c - 1;
      got.push_back(make_vertex(pc, r, held_sample, left_height, upper_row[pc], s, 1'b0));
      upper_row[pc] = held_sample;
      left_height = held_sample;
    end
    if (c == w - 1) begin
      // last column: right neighbour clamped to the centre
      last = (r == h - 1);
      got.push_back(make_vertex(c, r, s, left_height, upper_row[c], s, last));
      upper_row[c] = s;
      held_valid = 1'b0;
      next_col = 0;
      next_row = last ? 0 : r + 1;
    end else begin
      held_sample = s;
      held_valid = 1'b1;
      next_col = c + 1;
      next_row = r;
    end
    if (got.size() > 0) got[got.size() - 1].run_end = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices owed", cycles, vertex_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long holdoff on request, a quiet stretch
  // ---------------------------------------------------------------------------
  int  hold_left;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request && !hold_done) begin
      // long holdoff so the block backs up into its input
      hold_done <= 1'b1;
      hold_left <= 700;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_out || ($urandom_range(0, 99) >= 15);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected vertex beat col %0d row %0d", out_column, out_row);
      end else begin
        want = vertex_q.pop_front();
        vertices_seen <= vertices_seen + 1;
        if (out_map_end) maps_seen <= maps_seen + 1;
        if (out_column !== want.col || out_row !== want.row ||
            out_vertex_height !== want.vh || out_normal_x !== want.nx ||
            out_normal_y !== want.ny || out_normal_z !== want.nz ||
            out_run_end !== want.run_end || out_map_end !== want.map_end) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("vertex mismatch exp col %0d row %0d h %0d n %0d %0d %0d re %b me %b",
                     want.col, want.row, want.vh, $signed(want.nx), $signed(want.ny),
                     $signed(want.nz), want.run_end, want.map_end);
            $display("                got col %0d row %0d h %0d n %0d %0d %0d re %b me %b",
                     out_column, out_row, out_vertex_height, out_normal_x, out_normal_y,
                     out_normal_z, out_run_end, out_map_end);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  bit quiet_in;

  // offer one sample and hold it until accepted; valid stays up afterwards
  task automatic send_sample(logic [7:0] s, logic typed, vertex_t typed_want);
    vertex_t got[$];
    if (!quiet_in && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_height_sample <= s;
    do @(posedge clk); while (!in_ready);
    walk_sample(s, got);
    if (typed) vertex_q.push_back(typed_want);
    else foreach (got[i]) vertex_q.push_back(got[i]);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAP_WIDTH, REG_MAP_HEIGHT: begin
        if (idx == REG_MAP_WIDTH) width_reg = val;
        else height_reg = val;
        // map restarts at its origin, held sample dropped
        next_col = 0;
        next_row = 0;
        held_valid = 1'b0;
      end
      REG_HEIGHT_DIV: divisor_reg = val[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic dir_row_t row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    dir_row_t d;
    d = '{kind: STEP_REG, idx: idx, val: val, smp: '0, typed: 1'b0, want: '0};
    return d;
  endfunction

  function automatic dir_row_t row_smp(logic [7:0] s);
    dir_row_t d;
    d = '{kind: STEP_SAMPLE, idx: '0, val: '0, smp: s, typed: 1'b0, want: '0};
    return d;
  endfunction

  // first row under reset settings: flat normal, height h of the point before s
  function automatic dir_row_t row_flat(logic [7:0] s, int c, logic [7:0] h);
    dir_row_t d;
    d = row_smp(s);
    d.typed = 1'b1;
    d.want = '{col: OUT_POS_W'(c), row: '0, vh: h, nx: '0, ny: Q15_ONE, nz: '0,
               run_end: 1'b1, map_end: 1'b0};
    return d;
  endfunction

  // sample source: uniform, extremes only, or a smooth walk
  function automatic logic [7:0] pick_sample(int mode, logic [7:0] prev);
    int t;
    case (mode)
      1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      2: begin
        t = int'(prev) + $urandom_range(0, 16) - 8;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_map(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [7:0] dv,
                         int n, bit pause_mid);
    logic [7:0] s;
    int mode;
    vertex_t none;
    none = '0;
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    write_reg(REG_HEIGHT_DIV, CFG_W'(dv));
    mode = $urandom_range(0, 3);
    if (mode == 3) mode = 0;
    s = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        // sender waits for every owed vertex mid-map
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertex_q.size() != 0) @(posedge clk);
      end
      s = pick_sample(mode, s);
      send_sample(s, 1'b0, none);
    end
  endtask

  initial begin
    dir_row_t dir_tab[$];
    int n, wv, hv;
    logic [7:0] dv;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_height_sample = '0;
    samples_sent = 0;
    hold_request = 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    foreach (upper_row[i]) upper_row[i] = '0;
    held_sample = '0;
    left_height = '0;
    held_valid = 1'b0;
    next_col = 0;
    next_row = 0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    divisor_reg = RESET_DIV;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: reset settings first, then narrow maps and odd registers
    dir_tab.push_back(row_smp(8'h00));              // first of a row: nothing out
    dir_tab.push_back(row_flat(8'hff, 0, 8'h00));
    dir_tab.push_back(row_flat(8'h80, 1, 8'hff));
    dir_tab.push_back(row_smp(8'h07));
    dir_tab.push_back(row_reg(REG_HEIGHT_DIV, 11'd0));  // divide by zero gives 255
    dir_tab.push_back(row_reg(REG_MAP_WIDTH, 11'd0));   // clamps to 2
    dir_tab.push_back(row_reg(REG_MAP_HEIGHT, 11'd1));  // clamps to 2
    dir_tab.push_back(row_reg(REG_NONE, 11'h7ff));      // ignored
    dir_tab.push_back(row_smp(8'd200));
    dir_tab.push_back(row_smp(8'd100));
    dir_tab.push_back(row_smp(8'hff));
    dir_tab.push_back(row_smp(8'h00));                  // end of map
    dir_tab.push_back(row_smp(8'h00));
    dir_tab.push_back(row_smp(8'hff));
    dir_tab.push_back(row_reg(REG_HEIGHT_DIV, 11'd255));
    dir_tab.push_back(row_reg(REG_MAP_WIDTH, 11'd3));
    dir_tab.push_back(row_reg(REG_MAP_HEIGHT, 11'd3));
    for (int i = 0; i < 9; i++) dir_tab.push_back(row_smp((i % 2) ? 8'h00 : 8'hff));
    dir_tab.push_back(row_reg(REG_HEIGHT_DIV, 11'd1));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row_smp(8'h00));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row_smp(8'hff));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row_smp(8'h55 << (i % 2)));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_REG) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
    end

    // random part
    // one full row at the widest map, with the long receiver holdoff inside
    fork
      begin
        repeat (2000) @(posedge clk);
        hold_request = 1'b1;
      end
    join_none
    run_map(11'h7ff, 11'd2, 8'($urandom_range(0, 255)), 1030, 1'b0);
    // tall narrow map, no idling on either side
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    run_map(11'd2, 11'h7ff, 8'd1, 300, 1'b1);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    while (samples_sent < 1800) begin
      wv = $urandom_range(2, 12);
      hv = $urandom_range(2, 6);
      if ($urandom_range(0, 7) == 0) wv = $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0) hv = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0: dv = 8'd0;
        1: dv = 8'd1;
        2: dv = 8'd255;
        default: dv = 8'($urandom_range(0, 255));
      endcase
      n = (wv < 2 ? 2 : wv) * (hv < 2 ? 2 : hv) * $urandom_range(1, 2);
      // some maps are cut short by the next register write
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      run_map(CFG_W'(wv), CFG_W'(hv), dv, n, $urandom_range(0, 9) == 0);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d samples, %0d vertices, %0d complete maps", samples_sent,
             vertices_seen, maps_seen);
    $display("widths 2..1024, clamped sizes, divisors 0..255, long output holdoff");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/hvn_pkg.sv
src/hvn_ctrl.sv
src/hvn_norm.sv
src/hvn_dp.sv
src/heightmap_vertex_normal_generator.sv
src/hvn_checker.sv
sim/heightmap_vertex_normal_generator_test.sv
